// ===== sv/gfde_pkg.sv =====
// Package: shared types and constants for the greyscale draw engine.
package gfde_pkg;

    localparam int unsigned ScrW   = 256;
    localparam int unsigned ScrH   = 64;
    localparam int unsigned XW     = $clog2(ScrW);
    localparam int unsigned YW     = $clog2(ScrH);
    localparam int unsigned AddrW  = XW + YW;
    localparam int unsigned Depth  = ScrW * ScrH;
    localparam int unsigned ShadeW = 4;
    localparam int unsigned CoordW = 12;

    localparam logic [ShadeW-1:0] White = 4'hF;

    typedef logic signed [CoordW-1:0] t_coord;

    typedef enum logic [2:0] {
        ACT_SET     = 3'd0,
        ACT_ADD     = 3'd1,
        ACT_GET     = 3'd2,
        ACT_FILL    = 3'd3,
        ACT_RECT    = 3'd4,
        ACT_OUTLINE = 3'd5,
        ACT_LINE    = 3'd6,
        ACT_TAKE    = 3'd7
    } t_action;

    typedef struct packed {
        logic [2:0]        action;
        t_coord            ax;
        t_coord            ay;
        t_coord            bx;
        t_coord            by;
        logic [ShadeW-1:0] grey;
    } t_in;

    typedef struct packed {
        logic [ShadeW-1:0] pixel_value;
        t_coord            win_left;
        t_coord            win_right;
        t_coord            win_top;
        t_coord            win_bottom;
    } t_out;

    // Pixel write request from the draw sequencer to the store port
    typedef struct packed {
        logic              wr;
        logic              orm;
        logic signed [13:0] x;
        logic signed [13:0] y;
        logic [ShadeW-1:0] shade;
    } t_px_req;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GETRD,
        ST_GETWAIT,
        ST_RECT,
        ST_LINEPREP,
        ST_DIV,
        ST_HVD,
        ST_WU,
        ST_WU2,
        ST_LAST,
        ST_ORRD,
        ST_ORWR,
        ST_OUT
    } t_state;

endpackage

// ===== sv/gfde_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module gfde_ram #(
    parameter int unsigned DataW = 4,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [DataW-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [DataW-1:0]         o_rdata
);

    logic [DataW-1:0] r_mem [Depth];
    logic [DataW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/gfde_div.sv =====
// Restoring divider: (num << 16) / den, one quotient bit per cycle.
module gfde_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [11:0] i_num,
    input  logic [11:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quot
);

    logic [12:0] r_rem, n_rem;
    logic [27:0] r_sh;
    logic [11:0] r_den;
    logic [15:0] r_q;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [13:0] trial;

    // Shift in one dividend bit, try a subtract
    always_comb begin
        trial = {r_rem, r_sh[27]} - {2'b0, r_den};
        n_rem = trial[13] ? {r_rem[11:0], r_sh[27]} : trial[12:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd28;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_sh  <= {i_num, 16'b0};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_sh  <= {r_sh[26:0], 1'b0};
            r_q   <= {r_q[14:0], ~trial[13]};
        end
    end

    assign o_done = r_busy && (r_cnt == 5'd1);
    assign o_quot = {r_q[14:0], ~trial[13]};

endmodule

// ===== sv/gfde_store.sv =====
// Pixel store port: clipping, address forming, OR read-modify-write, clearing.
module gfde_store (
    input  logic                         i_clk,
    input  gfde_pkg::t_px_req            i_req,
    input  logic                         i_clr,
    input  logic [gfde_pkg::AddrW-1:0]   i_clr_addr,
    input  logic [gfde_pkg::ShadeW-1:0]  i_clr_shade,
    input  logic                         i_rd,
    input  logic [gfde_pkg::AddrW-1:0]   i_rd_addr,
    output logic [gfde_pkg::ShadeW-1:0]  o_rdata
);
    import gfde_pkg::*;

    logic              onscr;
    logic              we;
    logic [AddrW-1:0]  waddr;
    logic [ShadeW-1:0] wdata;
    logic [AddrW-1:0]  px_addr;

    // Clip and form the pixel address
    always_comb begin
        onscr   = (i_req.x >= 0) && (i_req.x < 14'(ScrW)) &&
                  (i_req.y >= 0) && (i_req.y < 14'(ScrH));
        px_addr = {i_req.y[YW-1:0], i_req.x[XW-1:0]};
        if (i_clr) begin
            we    = 1'b1;
            waddr = i_clr_addr;
            wdata = i_clr_shade;
        end else begin
            we    = i_req.wr && onscr;
            waddr = px_addr;
            wdata = i_req.orm ? (i_req.shade | o_rdata) : i_req.shade;
        end
    end

    gfde_ram #(.DataW(ShadeW), .Depth(Depth)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_rd ? i_rd_addr : px_addr),
        .o_rdata (o_rdata)
    );

endmodule

// ===== sv/greyscale_framebuffer_draw_engine.sv =====
// Top level: greyscale frame store drawing engine with dirty window.
//
// Input channel i_in_valid/o_in_stall carries one action (set, OR, get, fill
// all, fill rect, outline rect, anti-aliased line, take window); the output
// channel o_out_valid/i_out_stall returns exactly one result per action:
// the shade read by get (zero otherwise) and the dirty window.
// One action at a time: the pixel store is a single RAM with one write port,
// so the cost is set by the pixel writes, one per cycle. Work per action:
//   set writes the pixel, OR reads then writes it, get reads it,
//   fill all writes every entry, a rectangle walks its pixels in turn (outline
//   walks the whole clamped box), a line does a setup step, a division and
//   two writes per step (horizontal, vertical and diagonal lines one per step).
// o_in_stall drops in the cycle after the result transfer.
// Reset: after i_rst_n is released a clearing pass writes zero to all
// WIDTH*HEIGHT = 16384 entries, one per cycle; o_in_stall stays high meanwhile
// and no result is produced for it.
// The result sits in an output register; while i_out_stall is high it holds
// and no new action is taken until it has been transferred.
module greyscale_framebuffer_draw_engine (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  gfde_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output gfde_pkg::t_out   o_out
);
    import gfde_pkg::*;

    t_state r_state, n_state;
    t_in    r_cmd;
    t_out   r_out;
    logic   r_ovalid;

    t_coord r_wl, r_wr, r_wt, r_wb;
    logic [AddrW-1:0] r_clr_addr;
    logic [ShadeW-1:0] r_clr_shade;

    // Draw walkers
    logic signed [13:0] r_x, r_y, r_x0, r_x1, r_y0, r_y1, r_ex, r_ey;
    logic signed [13:0] r_dir;
    logic [12:0] r_cnt;
    logic [15:0] r_acc, r_adj;
    logic        r_ymaj;
    logic [ShadeW-1:0] r_w;

    t_px_req req;
    logic    store_rd;
    logic [AddrW-1:0] rd_addr;
    logic [ShadeW-1:0] rdata;
    logic    clr;
    logic    div_start, div_done;
    logic [15:0] div_q;

    logic accept;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || r_ovalid;

    // Clamp helpers
    function automatic logic signed [13:0] clampv(t_coord v, int unsigned lim);
        logic signed [13:0] e;
        e = 14'(v);
        if (e < 0) return '0;
        if (e > 14'(lim)) return 14'(lim);
        return e;
    endfunction

    logic signed [13:0] cax, cbx, cay, cby, lx0, ly0, lx1, ly1, ldx, ldy;
    always_comb begin
        // rectangle corners are clamped from the incoming transfer
        cax = clampv(i_in.ax, ScrW - 1);
        cbx = clampv(i_in.bx, ScrW - 1);
        cay = clampv(i_in.ay, ScrH - 1);
        cby = clampv(i_in.by, ScrH - 1);
        if (r_cmd.ay > r_cmd.by) begin
            lx0 = 14'(r_cmd.bx); ly0 = 14'(r_cmd.by);
            lx1 = 14'(r_cmd.ax); ly1 = 14'(r_cmd.ay);
        end else begin
            lx0 = 14'(r_cmd.ax); ly0 = 14'(r_cmd.ay);
            lx1 = 14'(r_cmd.bx); ly1 = 14'(r_cmd.by);
        end
        ldx = (lx1 >= lx0) ? lx1 - lx0 : lx0 - lx1;
        ldy = ly1 - ly0;
    end

    // Accumulator step
    logic [15:0] acc_n;
    logic        wrapc;
    assign acc_n = r_acc + r_adj;
    assign wrapc = (acc_n <= r_acc);

    // Stepped Wu position: main pixel of this step
    logic signed [13:0] wu_x, wu_y;
    assign wu_x = r_ymaj ? (wrapc ? r_x + r_dir : r_x) : r_x + r_dir;
    assign wu_y = r_ymaj ? r_y + 14'sd1 : (wrapc ? r_y + 14'sd1 : r_y);

    // Next state and store requests
    always_comb begin
        n_state   = r_state;
        req       = '0;
        store_rd  = 1'b0;
        rd_addr   = '0;
        clr       = (r_state == ST_CLEAR);
        div_start = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AddrW'(Depth - 1))
                    n_state = (r_cmd.action == ACT_FILL) ? ST_OUT : ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_action'(i_in.action))
                        ACT_SET:     n_state = ST_ORWR;
                        ACT_ADD:     n_state = ST_ORRD;
                        ACT_GET:     n_state = ST_GETRD;
                        ACT_FILL:    n_state = ST_CLEAR;
                        ACT_RECT:    n_state = ST_RECT;
                        ACT_OUTLINE: n_state = ST_RECT;
                        ACT_LINE:    n_state = ST_LINEPREP;
                        ACT_TAKE:    n_state = ST_OUT;
                        default:     n_state = ST_OUT;
                    endcase
                end
            end
            ST_GETRD: begin
                store_rd = 1'b1;
                rd_addr  = {r_cmd.ay[YW-1:0], r_cmd.ax[XW-1:0]};
                n_state  = ST_GETWAIT;
            end
            // keep the read address so the data is still there at the result stage
            ST_GETWAIT: begin
                store_rd = 1'b1;
                rd_addr  = {r_cmd.ay[YW-1:0], r_cmd.ax[XW-1:0]};
                n_state  = ST_OUT;
            end
            ST_ORRD: begin
                req.x = 14'(r_cmd.ax); req.y = 14'(r_cmd.ay);
                n_state = ST_ORWR;
            end
            ST_ORWR: begin
                req.wr = 1'b1;
                req.orm = (r_cmd.action == ACT_ADD);
                req.x = 14'(r_cmd.ax); req.y = 14'(r_cmd.ay);
                req.shade = r_cmd.grey;
                n_state = ST_OUT;
            end
            ST_RECT: begin
                req.x = r_x; req.y = r_y; req.shade = r_cmd.grey;
                req.wr = (r_cmd.action == ACT_RECT) || r_x == r_x0 || r_x == r_x1
                         || r_y == r_y0 || r_y == r_y1;
                if (r_x == r_x1 && r_y == r_y1) n_state = ST_OUT;
            end
            ST_LINEPREP: begin
                req.wr = 1'b1; req.x = lx0; req.y = ly0; req.shade = White;
                if (ldy == 0 || ldx == 0 || ldx == ldy) begin
                    n_state = (ldx == 0 && ldy == 0) ? ST_OUT : ST_HVD;
                end else begin
                    div_start = 1'b1;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: if (div_done) n_state = (r_cnt == 13'd1) ? ST_LAST : ST_WU;
            ST_HVD: begin
                req.wr = 1'b1; req.x = r_x; req.y = r_y; req.shade = White;
                if (r_cnt == 13'd1) n_state = ST_OUT;
            end
            ST_WU: begin
                req.wr = 1'b1; req.x = wu_x; req.y = wu_y;
                req.shade = acc_n[15:12] ^ White;
                n_state = ST_WU2;
            end
            ST_WU2: begin
                req.wr = 1'b1; req.shade = r_w;
                req.x = r_ymaj ? r_x + r_dir : r_x;
                req.y = r_ymaj ? r_y : r_y + 14'sd1;
                n_state = (r_cnt == 13'd2) ? ST_LAST : ST_WU;
            end
            ST_LAST: begin
                req.wr = 1'b1; req.x = r_ex; req.y = r_ey; req.shade = White;
                n_state = ST_OUT;
            end
            ST_OUT: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_ovalid   <= 1'b0;
            r_clr_addr <= '0;
            r_clr_shade <= '0;
            r_wl <= t_coord'(ScrW - 1); r_wr <= '0;
            r_wt <= t_coord'(ScrH - 1); r_wb <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + AddrW'(1);
            if (r_ovalid && !i_out_stall) r_ovalid <= 1'b0;
            if (accept) begin
                r_clr_addr  <= '0;
                r_clr_shade <= i_in.grey;
                if (t_action'(i_in.action) == ACT_FILL) begin
                    r_wl <= '0; r_wr <= t_coord'(ScrW - 1);
                    r_wt <= '0; r_wb <= t_coord'(ScrH - 1);
                end
            end
            // Window merge for rectangles and lines
            if (r_state == ST_IDLE && !accept) begin
                r_wl <= r_wl;
            end
            if (r_state == ST_OUT) begin
                r_ovalid <= 1'b1;
                if (r_cmd.action == ACT_TAKE) begin
                    r_wl <= t_coord'(ScrW - 1); r_wr <= '0;
                    r_wt <= t_coord'(ScrH - 1); r_wb <= '0;
                end
            end
            if (r_state == ST_RECT && n_state == ST_RECT && r_x == r_x0 && r_y == r_y0) begin
                if (t_coord'(r_x0) < r_wl) r_wl <= t_coord'(r_x0);
                if (t_coord'(r_x1) > r_wr) r_wr <= t_coord'(r_x1);
                if (t_coord'(r_y0) < r_wt) r_wt <= t_coord'(r_y0);
                if (t_coord'(r_y1) > r_wb) r_wb <= t_coord'(r_y1);
            end else if (r_state == ST_RECT && n_state == ST_OUT && r_x == r_x0
                         && r_y == r_y0) begin
                if (t_coord'(r_x0) < r_wl) r_wl <= t_coord'(r_x0);
                if (t_coord'(r_x1) > r_wr) r_wr <= t_coord'(r_x1);
                if (t_coord'(r_y0) < r_wt) r_wt <= t_coord'(r_y0);
                if (t_coord'(r_y1) > r_wb) r_wb <= t_coord'(r_y1);
            end
            if (r_state == ST_LINEPREP) begin
                if (t_coord'((lx0 < lx1) ? lx0 : lx1) < r_wl)
                    r_wl <= t_coord'((lx0 < lx1) ? lx0 : lx1);
                if (t_coord'((lx0 < lx1) ? lx1 : lx0) > r_wr)
                    r_wr <= t_coord'((lx0 < lx1) ? lx1 : lx0);
                if (t_coord'(ly0) < r_wt) r_wt <= t_coord'(ly0);
                if (t_coord'(ly1) > r_wb) r_wb <= t_coord'(ly1);
            end
        end
    end

    // Command, walker and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd.action <= ACT_TAKE;
        end else if (accept) begin
            r_cmd <= i_in;
            r_x   <= (cax <= cbx) ? cax : cbx;
            r_y   <= (cay <= cby) ? cay : cby;
        end
        unique case (r_state)
            ST_IDLE: r_cnt <= 13'd0;
            ST_RECT: begin
                if (r_x == r_x1) begin
                    r_x <= r_x0;
                    r_y <= r_y + 14'sd1;
                end else begin
                    r_x <= r_x + 14'sd1;
                end
            end
            ST_LINEPREP: begin
                r_dir <= (lx1 >= lx0) ? 14'sd1 : -14'sd1;
                r_ex  <= lx1; r_ey <= ly1;
                r_acc <= '0;
                r_ymaj <= ldy > ldx;
                r_x   <= (ldy == 0 || ldx == ldy) ? lx0 + ((lx1 >= lx0) ? 14'sd1 : -14'sd1)
                                                 : lx0;
                r_y   <= (ldy == 0 || (ldx != 0 && ldx != ldy)) ? ly0 : ly0 + 14'sd1;
                r_cnt <= (ldy == 0) ? ldx[12:0] : ((ldx == 0 || ldx == ldy) ? ldy[12:0]
                         : ((ldy > ldx) ? ldy[12:0] : ldx[12:0]));
            end
            ST_DIV: if (div_done) r_adj <= div_q;
            ST_HVD: begin
                r_cnt <= r_cnt - 13'd1;
                r_x <= (ldy == 0 || ldx == ldy) ? r_x + r_dir : r_x;
                r_y <= (ldy == 0) ? r_y : r_y + 14'sd1;
            end
            ST_WU: begin
                r_acc <= acc_n;
                r_w   <= acc_n[15:12];
                r_x   <= wu_x;
                r_y   <= wu_y;
            end
            ST_WU2: r_cnt <= r_cnt - 13'd1;
            default: ;
        endcase
        // Clamped and ordered rectangle corners, taken with the transfer
        if (r_state == ST_IDLE && accept) begin
            r_x0 <= (cax <= cbx) ? cax : cbx;
            r_x1 <= (cax <= cbx) ? cbx : cax;
            r_y0 <= (cay <= cby) ? cay : cby;
            r_y1 <= (cay <= cby) ? cby : cay;
        end
        if (r_state == ST_OUT) begin
            r_out.pixel_value <= (r_cmd.action == ACT_GET) ? rdata : '0;
            r_out.win_left    <= r_wl;
            r_out.win_right   <= r_wr;
            r_out.win_top     <= r_wt;
            r_out.win_bottom  <= r_wb;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    gfde_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ((ldy > ldx) ? ldx[11:0] : ldy[11:0]),
        .i_den   ((ldy > ldx) ? ldy[11:0] : ldx[11:0]),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    gfde_store u_store (
        .i_clk       (i_clk),
        .i_req       (req),
        .i_clr       (clr),
        .i_clr_addr  (r_clr_addr),
        .i_clr_shade (r_clr_shade),
        .i_rd        (store_rd),
        .i_rd_addr   (rd_addr),
        .o_rdata     (rdata)
    );

    // Output only valid from the result stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result without finishing an action");
    // No new item while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while result pending");
    // Clear pass never overlaps a draw write request
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !req.wr)
        else $error("pixel write during clear");

endmodule
